@@ design/sfd_pkg.sv @@
// Shared types and constants for the sensor frame decoder.
`timescale 1ns / 1ps

package sfd_pkg;

  // Frame phase, one-hot coded.
  typedef enum logic [4:0] {
    PH_CMD     = 5'b00001,
    PH_LEN_LO  = 5'b00010,
    PH_LEN_HI  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CHECK   = 5'b10000
  } sfd_phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SUM  = 2'd1,
    ST_ZERO_LEN = 2'd2
  } sfd_status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_REPORT  = 1'b1
  } sfd_kind_e;

  localparam logic [7:0] NoCheckMark = 8'h88;
  localparam logic [7:0] SumBase     = 8'hAA;

  // One result as it leaves the decoder.
  typedef struct packed {
    sfd_kind_e   kind;
    logic [7:0]  data_byte;
    logic [3:0]  category;
    logic [2:0]  command;
    logic [15:0] body_len;
    sfd_status_e status;
    logic        last;
  } sfd_result_t;

endpackage

@@ design/sfd_parser.sv @@
// Frame parser: header tracking, running checksum and result formation.
`timescale 1ns / 1ps

module sfd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          in_byte_i,
  output logic                res_valid_o,
  output sfd_pkg::sfd_result_t res_o
);

  sfd_pkg::sfd_phase_e phase_q, phase_d;
  logic [7:0]  held_q, held_d;
  logic [15:0] len_q, len_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  sum_q, sum_d;

  logic [15:0] len_full;
  logic [15:0] left_dec;
  logic [15:0] len_less_one;
  logic [7:0]  expected;

  assign len_full     = {in_byte_i, len_q[7:0]};
  assign left_dec     = left_q - 16'd1;
  assign len_less_one = len_q - 16'd1;
  assign expected     = sfd_pkg::SumBase - sum_q;

  always_comb begin
    phase_d     = phase_q;
    held_d      = held_q;
    len_d       = len_q;
    left_d      = left_q;
    sum_d       = sum_q;
    res_valid_o = 1'b0;
    res_o.kind        = sfd_pkg::KIND_PAYLOAD;
    res_o.data_byte   = 8'h00;
    res_o.category    = held_q[7:4];
    res_o.command     = held_q[3:1];
    res_o.body_len    = len_less_one;
    res_o.status      = sfd_pkg::ST_OK;
    res_o.last        = 1'b0;
    unique case (phase_q)
      sfd_pkg::PH_LEN_LO: begin
        len_d   = {8'h00, in_byte_i};
        sum_d   = sum_q + in_byte_i;
        phase_d = sfd_pkg::PH_LEN_HI;
      end
      sfd_pkg::PH_LEN_HI: begin
        len_d = len_full;
        sum_d = sum_q + in_byte_i;
        if (len_full == 16'd0) begin
          // No room for a checksum byte: report at once and start over.
          res_valid_o       = 1'b1;
          res_o.kind        = sfd_pkg::KIND_REPORT;
          res_o.body_len    = 16'd0;
          res_o.status      = sfd_pkg::ST_ZERO_LEN;
          res_o.last        = 1'b1;
          phase_d           = sfd_pkg::PH_CMD;
        end else begin
          left_d  = len_full - 16'd1;
          phase_d = (len_full == 16'd1) ? sfd_pkg::PH_CHECK : sfd_pkg::PH_PAYLOAD;
        end
      end
      sfd_pkg::PH_PAYLOAD: begin
        sum_d           = sum_q + in_byte_i;
        left_d          = left_dec;
        phase_d         = (left_dec == 16'd0) ? sfd_pkg::PH_CHECK : sfd_pkg::PH_PAYLOAD;
        res_valid_o     = 1'b1;
        res_o.data_byte = in_byte_i;
      end
      sfd_pkg::PH_CHECK: begin
        res_valid_o = 1'b1;
        res_o.kind  = sfd_pkg::KIND_REPORT;
        res_o.last  = 1'b1;
        res_o.status = (in_byte_i == sfd_pkg::NoCheckMark || in_byte_i == expected)
                       ? sfd_pkg::ST_OK : sfd_pkg::ST_BAD_SUM;
        phase_d     = sfd_pkg::PH_CMD;
      end
      default: begin
        held_d  = in_byte_i;
        sum_d   = in_byte_i;
        len_d   = 16'd0;
        left_d  = 16'd0;
        phase_d = sfd_pkg::PH_LEN_LO;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfd_pkg::PH_CMD;
      held_q  <= 8'h00;
      len_q   <= 16'd0;
      left_q  <= 16'd0;
      sum_q   <= 8'h00;
    end else if (accept_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      len_q   <= len_d;
      left_q  <= left_d;
      sum_q   <= sum_d;
    end
  end

endmodule

@@ design/sfd_out_buf.sv @@
// Result register with a skid stage, so input and output stall apart.
`timescale 1ns / 1ps

module sfd_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sfd_pkg::sfd_result_t push_data_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sfd_pkg::sfd_result_t out_data_o
);

  logic                 main_valid_q, main_valid_d;
  logic                 skid_valid_q, skid_valid_d;
  sfd_pkg::sfd_result_t main_q, main_d;
  sfd_pkg::sfd_result_t skid_q, skid_d;
  logic                 main_free;

  // The main register can take new data when empty or when its transfer completes.
  assign main_free = !main_valid_q || !out_stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (main_free) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        main_valid_d = 1'b0;
      end
    end else if (push_i) begin
      skid_d       = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

endmodule

@@ design/sensor_frame_decoder.sv @@
// Top level of the sensor frame decoder.
`timescale 1ns / 1ps

// Decodes framed sensor messages one byte per transfer: a command byte, a
// little-endian 16-bit length (payload plus checksum), the payload and a
// checksum byte. Every payload byte is passed on as a result, and the checksum
// byte (or a zero length field) yields a frame end report with status. The
// decoder takes one byte per clock cycle while in_stall_o is low; each byte is
// handled in the cycle it is accepted and its result is registered in the
// result register or its skid stage. Input stall rises only when the result
// register and its skid stage both hold a result the output has not yet taken.
module sensor_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  data_byte_o,
  output logic [3:0]  category_o,
  output logic [2:0]  command_o,
  output logic [15:0] body_len_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  logic                 accept;
  logic                 res_valid;
  logic                 buf_full;
  sfd_pkg::sfd_result_t res;
  sfd_pkg::sfd_result_t out_data;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  sfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sfd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign kind_o        = out_data.kind;
  assign data_byte_o   = out_data.data_byte;
  assign category_o    = out_data.category;
  assign command_o     = out_data.command;
  assign body_len_o    = out_data.body_len;
  assign status_o      = out_data.status;
  assign last_o        = out_data.last;

  // The skid stage only fills behind a waiting result.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // Payload byte results carry no status and never close a frame.
  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == sfd_pkg::KIND_PAYLOAD) |-> (status_o == sfd_pkg::ST_OK && !last_o))
    else $error("payload byte result with status or end mark");

  // A zero length report always gives a payload length of zero.
  a_zero_len_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == sfd_pkg::ST_ZERO_LEN) |-> (body_len_o == 16'd0 && last_o))
    else $error("zero length report with non-zero payload length");

  // A stalled result must not be replaced by a newer one.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(data_byte_o) && $stable(kind_o)))
    else $error("stalled result changed");

endmodule
